/* rtl/lant_pkg.sv */
// Shared types, codes and defaults for the Langton's ant stepper.
package lant_pkg;

  // Default grid store dimensions.
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  // Largest active size the size registers can select; larger values clamp to it.
  localparam int SIZE_LIMIT = 256;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_EDGES  = 2'd2;

  // Item modes.
  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_PLACE = 2'd2;

  // Headings, coded clockwise.
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // Turn amounts: a quarter turn counterclockwise or clockwise.
  localparam logic [1:0] TURN_CCW = 2'd3;
  localparam logic [1:0] TURN_CW  = 2'd1;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic       cell_value;
  } req_t;

  // Result transaction payload.
  typedef struct packed {
    logic       changed_valid;
    logic [7:0] changed_x;
    logic [7:0] changed_y;
    logic       changed_value;
    logic [7:0] ant_x;
    logic [7:0] ant_y;
    logic [1:0] ant_heading;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic idle;
    logic take;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/langton_ant_stepper_top.sv */
// Top level of the Langton's ant stepper.
//
// Requests arrive on the req channel (valid/ready) as a mode with a cell
// position and value: step the ant, write one cell, or place the ant at the
// center facing right. Every request transaction produces exactly one result
// transaction on the rsp channel (valid/ready), reporting the written cell,
// if any, and the ant's position and heading afterwards.
// A request is accepted in the idle state, which reads its grid row for the
// read-modify-write; the work state that follows writes the row back, moves
// the ant and loads the result register, and holds while the output register
// still has a result not taken. No new request is taken until the last one is done.
// After reset the block clears all MAX_ROWS grid rows, one row per cycle,
// with req_ready low; configuration writes are taken during that time.
// If the receiver stalls, a pending result stays in the output register and
// the next request may still be accepted; it then waits in its write-back
// state until the output register is free.
// Configuration (height, width, wrap) is written through cfg_wr_en, cfg_index
// and cfg_data with no handshake; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module langton_ant_stepper_top #(
  parameter int MAX_ROWS = lant_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lant_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  lant_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output lant_pkg::rsp_t                   rsp,
  input  logic                             cfg_wr_en,
  input  logic [lant_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lant_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lant_pkg::cmd_t cmd;
  lant_pkg::sts_t sts;

  // Sequencing of clear, accept and write-back.
  lant_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Grid store, ant state and result register.
  lant_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/lant_ctrl.sv */
// Controller state machine for the Langton's ant stepper.
module lant_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lant_pkg::sts_t sts,
  output lant_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WORK
  } state_t;

  state_t state;

  // State register: clear the grid after reset, then alternate accept and work.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid) state <= ST_WORK;
        end
        ST_WORK: begin
          if (!sts.out_busy) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Commands follow from the state, the request valid and the output busy flag.
  always_comb begin
    cmd.clr_wr = (state == ST_CLEAR);
    cmd.idle   = (state == ST_IDLE);
    cmd.take   = (state == ST_IDLE) && req_valid;
    cmd.commit = (state == ST_WORK) && !sts.out_busy;
  end

  assign req_ready = (state == ST_IDLE);

endmodule

/* rtl/lant_datapath.sv */
// Datapath of the Langton's ant stepper: grid store, ant registers and result register.
module lant_datapath #(
  parameter int MAX_ROWS = lant_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lant_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lant_pkg::req_t                    req,
  output lant_pkg::rsp_t                    rsp,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  input  logic                              cfg_wr_en,
  input  logic [lant_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lant_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  lant_pkg::cmd_t                    cmd,
  output lant_pkg::sts_t                    sts
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int LIM_H = (MAX_ROWS < lant_pkg::SIZE_LIMIT) ? MAX_ROWS : lant_pkg::SIZE_LIMIT;
  localparam int LIM_W = (MAX_COLS < lant_pkg::SIZE_LIMIT) ? MAX_COLS : lant_pkg::SIZE_LIMIT;
  localparam logic [8:0] LIM_H9 = 9'(LIM_H);
  localparam logic [8:0] LIM_W9 = 9'(LIM_W);
  localparam logic [7:0] HOME_ROW = 8'(LIM_H / 2);
  localparam logic [7:0] HOME_COL = 8'(LIM_W / 2);

  // Grid store: one row of cells per word.
  logic [MAX_COLS-1:0] store [MAX_ROWS];

  logic [MAX_COLS-1:0] rd_row;
  logic [MAX_COLS-1:0] mod_row;
  logic [MAX_COLS-1:0] wr_data;
  logic [RW-1:0]       rd_addr;
  logic [RW-1:0]       wr_addr;
  logic                wr_en;
  logic [RW-1:0]       clr_row;

  logic [8:0] grid_height;
  logic [8:0] grid_width;
  logic       wrap_edges;
  logic [8:0] eff_h;
  logic [8:0] eff_w;

  logic [7:0] ant_col;
  logic [7:0] ant_row;
  logic [1:0] ant_dir;
  logic [7:0] ant_col_next;
  logic [7:0] ant_row_next;
  logic [1:0] ant_dir_next;

  lant_pkg::req_t item;
  logic [1:0] sel_mode;
  logic [7:0] sel_y;
  logic [7:0] row_sel;
  logic [7:0] col_sel;
  logic       cur_bit;
  logic       new_bit;
  logic       in_range;
  logic       write_hit;
  logic [8:0] col_inc;
  logic [8:0] row_inc;
  logic [8:0] eff_h_m1;
  logic [8:0] eff_w_m1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= 9'(lant_pkg::SIZE_LIMIT);
      grid_width  <= 9'(lant_pkg::SIZE_LIMIT);
      wrap_edges  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lant_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[8:0];
        lant_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[8:0];
        lant_pkg::CFG_WRAP_EDGES:  wrap_edges  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective active size: zero acts as one, large values clamp to the store or to SIZE_LIMIT, whichever is smaller.
  always_comb begin
    if (grid_height == 9'd0) eff_h = 9'd1;
    else if (grid_height > LIM_H9) eff_h = LIM_H9;
    else eff_h = grid_height;
    if (grid_width == 9'd0) eff_w = 9'd1;
    else if (grid_width > LIM_W9) eff_w = LIM_W9;
    else eff_w = grid_width;
    eff_h_m1 = eff_h - 9'd1;
    eff_w_m1 = eff_w - 9'd1;
  end

  // Latch the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.take) item <= req;
  end

  // Read address comes from the incoming transaction while idle, else from the held one.
  always_comb begin
    if (cmd.idle) begin
      sel_mode = req.mode;
      sel_y    = req.cell_y;
    end else begin
      sel_mode = item.mode;
      sel_y    = item.cell_y;
    end
    rd_addr = (sel_mode == lant_pkg::MODE_WRITE) ? RW'(sel_y) : RW'(ant_row);
  end

  // Store read and write ports.
  always_ff @(posedge clk) begin
    rd_row <= store[rd_addr];
    if (wr_en) store[wr_addr] <= wr_data;
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr_wr) begin
      clr_row <= clr_row + RW'(1);
    end
  end

  assign sts.clr_last = (clr_row == RW'(MAX_ROWS - 1));

  // Cell update: the step inverts the cell under the ant, a write sets a cell.
  always_comb begin
    if (item.mode == lant_pkg::MODE_WRITE) begin
      row_sel = item.cell_y;
      col_sel = item.cell_x;
    end else begin
      row_sel = ant_row;
      col_sel = ant_col;
    end
    cur_bit  = rd_row[CW'(col_sel)];
    in_range = ({1'b0, item.cell_x} < eff_w) && ({1'b0, item.cell_y} < eff_h);
    new_bit  = (item.mode == lant_pkg::MODE_WRITE) ? item.cell_value : ~cur_bit;
    write_hit = (item.mode == lant_pkg::MODE_STEP) ||
                ((item.mode == lant_pkg::MODE_WRITE) && in_range);
    mod_row = rd_row;
    mod_row[CW'(col_sel)] = new_bit;
  end

  // Store write mux: clearing pass or the modified row.
  always_comb begin
    wr_en   = cmd.clr_wr || (cmd.commit && write_hit);
    wr_addr = cmd.clr_wr ? clr_row : RW'(row_sel);
    wr_data = cmd.clr_wr ? '0 : mod_row;
  end

  // Ant update: a step turns, then moves with wrap or holds at the edge; a place recenters the ant facing right.
  always_comb begin
    ant_col_next = ant_col;
    ant_row_next = ant_row;
    ant_dir_next = ant_dir;
    col_inc = {1'b0, ant_col} + 9'd1;
    row_inc = {1'b0, ant_row} + 9'd1;
    unique case (item.mode)
      lant_pkg::MODE_STEP: begin
        ant_dir_next = new_bit ? (ant_dir + lant_pkg::TURN_CCW) : (ant_dir + lant_pkg::TURN_CW);
        unique case (ant_dir_next)
          lant_pkg::HEAD_UP: begin
            if (ant_row != 8'd0) ant_row_next = ant_row - 8'd1;
            else if (wrap_edges) ant_row_next = eff_h_m1[7:0];
          end
          lant_pkg::HEAD_RIGHT: begin
            if (col_inc < eff_w) ant_col_next = col_inc[7:0];
            else if (wrap_edges) ant_col_next = 8'd0;
          end
          lant_pkg::HEAD_DOWN: begin
            if (row_inc < eff_h) ant_row_next = row_inc[7:0];
            else if (wrap_edges) ant_row_next = 8'd0;
          end
          default: begin
            if (ant_col != 8'd0) ant_col_next = ant_col - 8'd1;
            else if (wrap_edges) ant_col_next = eff_w_m1[7:0];
          end
        endcase
      end
      lant_pkg::MODE_PLACE: begin
        ant_col_next = eff_w[8:1];
        ant_row_next = eff_h[8:1];
        ant_dir_next = lant_pkg::HEAD_RIGHT;
      end
      default: ;
    endcase
  end

  // Ant registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ant_col <= HOME_COL;
      ant_row <= HOME_ROW;
      ant_dir <= lant_pkg::HEAD_RIGHT;
    end else if (cmd.commit) begin
      ant_col <= ant_col_next;
      ant_row <= ant_row_next;
      ant_dir <= ant_dir_next;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.changed_valid <= write_hit;
      rsp.changed_x     <= write_hit ? col_sel : 8'd0;
      rsp.changed_y     <= write_hit ? row_sel : 8'd0;
      rsp.changed_value <= write_hit ? new_bit : 1'b0;
      rsp.ant_x         <= ant_col_next;
      rsp.ant_y         <= ant_row_next;
      rsp.ant_heading   <= ant_dir_next;
    end
  end

  assign sts.out_busy = rsp_valid && !rsp_ready;

endmodule

/* test/tb_langton_ant_stepper_top.sv */
// Self-checking testbench for the Langton's ant stepper top level.
module tb_langton_ant_stepper_top;

  // The fourth mode code is unused; the block must report the ant and change nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;

  // One row of the directed plan: a register write or a request transaction.
  typedef struct packed {
    bit                               is_cfg;
    logic [lant_pkg::CFG_INDEX_W-1:0] reg_idx;
    logic [lant_pkg::CFG_DATA_W-1:0]  reg_val;
    lant_pkg::req_t                   item;
    bit                               typed;
    lant_pkg::rsp_t                   want;
  } drow_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             req_valid = 1'b0;
  logic                             req_ready;
  lant_pkg::req_t                   req = '0;
  logic                             rsp_valid;
  logic                             rsp_ready = 1'b0;
  lant_pkg::rsp_t                   rsp;
  logic                             cfg_wr_en = 1'b0;
  logic [lant_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lant_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Mirror of the block state: grid, ant and registers.
  bit                              grid_cells [0:255][0:255];
  int                              ant_col = 128;
  int                              ant_row = 128;
  logic [1:0]                      ant_dir = lant_pkg::HEAD_RIGHT;
  logic [lant_pkg::CFG_DATA_W-1:0] height_reg = 9'd256;
  logic [lant_pkg::CFG_DATA_W-1:0] width_reg = 9'd256;
  bit                              wrap_reg = 1'b0;

  lant_pkg::rsp_t pending_results [$];
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             send_quiet = 1'b0;
  bit             recv_quiet = 1'b0;
  drow_t          plan [0:26];

  langton_ant_stepper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Active size as the block sees it: zero acts as one, the top is 256.
  function automatic int eff_size(logic [lant_pkg::CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    return (v > lant_pkg::SIZE_LIMIT) ? lant_pkg::SIZE_LIMIT : int'(v);
  endfunction

  // Apply one request to the mirror state and return the result it causes.
  function automatic lant_pkg::rsp_t advance_ant(lant_pkg::req_t it);
    lant_pkg::rsp_t r;
    int             h;
    int             w;
    bit             flip;
    r = '0;
    h = eff_size(height_reg);
    w = eff_size(width_reg);
    case (it.mode)
      lant_pkg::MODE_STEP: begin
        flip = !grid_cells[ant_row][ant_col];
        grid_cells[ant_row][ant_col] = flip;
        r.changed_valid = 1'b1;
        r.changed_x = ant_col[7:0];
        r.changed_y = ant_row[7:0];
        r.changed_value = flip;
        ant_dir = ant_dir + (flip ? lant_pkg::TURN_CCW : lant_pkg::TURN_CW);
        // Moves toward zero just decrement; moves toward the far edge check the active size.
        case (ant_dir)
          lant_pkg::HEAD_UP: begin
            if (ant_row > 0) ant_row--;
            else if (wrap_reg) ant_row = h - 1;
          end
          lant_pkg::HEAD_RIGHT: begin
            if (ant_col + 1 <= w - 1) ant_col++;
            else if (wrap_reg) ant_col = 0;
          end
          lant_pkg::HEAD_DOWN: begin
            if (ant_row + 1 <= h - 1) ant_row++;
            else if (wrap_reg) ant_row = 0;
          end
          default: begin
            if (ant_col > 0) ant_col--;
            else if (wrap_reg) ant_col = w - 1;
          end
        endcase
      end
      lant_pkg::MODE_WRITE: begin
        if (it.cell_x < w && it.cell_y < h) begin
          grid_cells[it.cell_y][it.cell_x] = it.cell_value;
          r.changed_valid = 1'b1;
          r.changed_x = it.cell_x;
          r.changed_y = it.cell_y;
          r.changed_value = it.cell_value;
        end
      end
      lant_pkg::MODE_PLACE: begin
        ant_col = w / 2;
        ant_row = h / 2;
        ant_dir = lant_pkg::HEAD_RIGHT;
      end
      default: ;
    endcase
    r.ant_x = ant_col[7:0];
    r.ant_y = ant_row[7:0];
    r.ant_heading = ant_dir;
    return r;
  endfunction

  // Wait time for one transaction, with occasional stretches of none at all.
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [lant_pkg::CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      6: return 9'd0;
      7: return 9'd256;
      8: return 9'($urandom_range(257, 511));
      9: return 9'($urandom_range(1, 256));
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic drow_t cfg_row(logic [lant_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [lant_pkg::CFG_DATA_W-1:0] val);
    drow_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.reg_idx = idx;
    d.reg_val = val;
    return d;
  endfunction

  function automatic drow_t item_row(logic [1:0] m, logic [7:0] x, logic [7:0] y, logic v);
    drow_t d;
    d = '0;
    d.item = '{mode: m, cell_x: x, cell_y: y, cell_value: v};
    return d;
  endfunction

  function automatic drow_t known_row(logic [1:0] m, logic [7:0] x, logic [7:0] y, logic v,
                                     lant_pkg::rsp_t want);
    drow_t d;
    d = item_row(m, x, y, v);
    d.typed = 1'b1;
    d.want = want;
    return d;
  endfunction

  // Drive one request transaction and record its expected result on acceptance.
  // Entered and left at a falling edge.
  task automatic send_item(lant_pkg::req_t it, bit typed, lant_pkg::rsp_t want);
    int             gap;
    lant_pkg::rsp_t predicted;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = advance_ant(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Let the block go idle before touching its registers.
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [lant_pkg::CFG_INDEX_W-1:0] idx,
                           logic [lant_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      lant_pkg::CFG_GRID_HEIGHT: height_reg = val;
      lant_pkg::CFG_GRID_WIDTH:  width_reg = val;
      lant_pkg::CFG_WRAP_EDGES:  wrap_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: random stalls, and each accepted transaction is checked in order.
  initial begin
    int             stall;
    lant_pkg::rsp_t want;
    @(negedge clk);
    forever begin
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual %p", $time, rsp);
      end else begin
        want = pending_results.pop_front();
        check_field("changed_valid", want.changed_valid, rsp.changed_valid);
        check_field("changed_x", want.changed_x, rsp.changed_x);
        check_field("changed_y", want.changed_y, rsp.changed_y);
        check_field("changed_value", want.changed_value, rsp.changed_value);
        check_field("ant_x", want.ant_x, rsp.ant_x);
        check_field("ant_y", want.ant_y, rsp.ant_y);
        check_field("ant_heading", want.ant_heading, rsp.ant_heading);
      end
      @(negedge clk);
    end
  end

  // Run time guard.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Request side: reset, directed plan, then random phases.
  initial begin
    logic [lant_pkg::CFG_DATA_W-1:0] hv;
    logic [lant_pkg::CFG_DATA_W-1:0] wv;
    bit                              wrap_val;
    lant_pkg::req_t                  it;
    int                              pick;
    int                              w;
    int                              h;

    // Directed plan. Typed results hold from reset at a glance; the rest are predicted.
    plan = '{
      known_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0,
                lant_pkg::rsp_t'{1'b1, 8'd128, 8'd128, 1'b1, 8'd128, 8'd127,
                                 lant_pkg::HEAD_UP}),
      known_row(lant_pkg::MODE_WRITE, 8'd255, 8'd255, 1'b1,
                lant_pkg::rsp_t'{1'b1, 8'd255, 8'd255, 1'b1, 8'd128, 8'd127,
                                 lant_pkg::HEAD_UP}),
      // Writing a value the cell already holds still reports a change.
      known_row(lant_pkg::MODE_WRITE, 8'd0, 8'd0, 1'b0,
                lant_pkg::rsp_t'{1'b1, 8'd0, 8'd0, 1'b0, 8'd128, 8'd127,
                                 lant_pkg::HEAD_UP}),
      known_row(MODE_UNUSED, 8'hFF, 8'hFF, 1'b1,
                lant_pkg::rsp_t'{1'b0, 8'd0, 8'd0, 1'b0, 8'd128, 8'd127,
                                 lant_pkg::HEAD_UP}),
      known_row(lant_pkg::MODE_PLACE, 8'hAA, 8'h55, 1'b1,
                lant_pkg::rsp_t'{1'b0, 8'd0, 8'd0, 1'b0, 8'd128, 8'd128,
                                 lant_pkg::HEAD_RIGHT}),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      item_row(lant_pkg::MODE_WRITE, 8'd128, 8'd129, 1'b1),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      // Zero sizes act as a one by one grid; the ant is now far outside it.
      cfg_row(lant_pkg::CFG_GRID_HEIGHT, 9'd0),
      cfg_row(lant_pkg::CFG_GRID_WIDTH, 9'd0),
      cfg_row(lant_pkg::CFG_WRAP_EDGES, 9'd1),
      item_row(lant_pkg::MODE_WRITE, 8'd1, 8'd0, 1'b1),
      item_row(lant_pkg::MODE_WRITE, 8'd0, 8'd0, 1'b1),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      known_row(lant_pkg::MODE_PLACE, 8'd0, 8'd0, 1'b0,
                lant_pkg::rsp_t'{1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0,
                                 lant_pkg::HEAD_RIGHT}),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      // Sizes above the limit act as 256.
      cfg_row(lant_pkg::CFG_GRID_HEIGHT, 9'd511),
      cfg_row(lant_pkg::CFG_GRID_WIDTH, 9'd300),
      cfg_row(lant_pkg::CFG_WRAP_EDGES, 9'd0),
      known_row(lant_pkg::MODE_PLACE, 8'd0, 8'd0, 1'b0,
                lant_pkg::rsp_t'{1'b0, 8'd0, 8'd0, 1'b0, 8'd128, 8'd128,
                                 lant_pkg::HEAD_RIGHT}),
      known_row(lant_pkg::MODE_WRITE, 8'd255, 8'd255, 1'b0,
                lant_pkg::rsp_t'{1'b1, 8'd255, 8'd255, 1'b0, 8'd128, 8'd128,
                                 lant_pkg::HEAD_RIGHT}),
      item_row(lant_pkg::MODE_STEP, 8'd0, 8'd0, 1'b0),
      item_row(MODE_UNUSED, 8'h55, 8'hAA, 1'b0)
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: the first few pin the size extremes, the rest draw sizes.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin hv = 9'd1;   wv = 9'd1;   wrap_val = 1'b1; end
        1: begin hv = 9'd256; wv = 9'd256; wrap_val = 1'b0; end
        2: begin hv = 9'd2;   wv = 9'd511; wrap_val = 1'b1; end
        3: begin hv = 9'd511; wv = 9'd2;   wrap_val = 1'b0; end
        default: begin
          hv = pick_size();
          wv = pick_size();
          wrap_val = 1'($urandom_range(0, 1));
        end
      endcase
      settle();
      write_reg(lant_pkg::CFG_GRID_HEIGHT, hv);
      write_reg(lant_pkg::CFG_GRID_WIDTH, wv);
      write_reg(lant_pkg::CFG_WRAP_EDGES, {8'd0, wrap_val});
      h = eff_size(height_reg);
      w = eff_size(width_reg);

      // Sometimes leave the ant where it was, possibly outside the new size.
      if ($urandom_range(0, 1) == 1) begin
        it = '{mode: lant_pkg::MODE_PLACE, cell_x: 8'($urandom), cell_y: 8'($urandom),
               cell_value: 1'($urandom)};
        send_item(it, 1'b0, '0);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.cell_x = 8'($urandom_range(0, 255));
        it.cell_y = 8'($urandom_range(0, 255));
        it.cell_value = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          it.mode = lant_pkg::MODE_STEP;
        end else if (pick < 85) begin
          it.mode = lant_pkg::MODE_WRITE;
          // Mostly writes inside the active size, the rest anywhere.
          if ($urandom_range(0, 3) != 0) begin
            it.cell_x = 8'($urandom_range(0, w - 1));
            it.cell_y = 8'($urandom_range(0, h - 1));
          end
        end else if (pick < 93) begin
          it.mode = lant_pkg::MODE_PLACE;
        end else begin
          it.mode = MODE_UNUSED;
        end
        send_item(it, 1'b0, '0);
      end
    end

    // Drain the remaining results and let the block finish its write-back.
    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
